@@ hdl/stmp_pkg.sv @@
// Shared types, register codes and the quarter-cosine table function for the mixer.
// No dependencies; used by stmp_front, stmp_back and the top level.
package stmp_pkg;

    // Register indexes on the configuration channel (tracks use indexes below REG_MASTER)
    localparam logic [2:0] REG_MASTER = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;

    localparam int SETTING_BITS = 34;
    localparam int BIT_MUTE     = 32;
    localparam int BIT_SOLO     = 33;

    localparam logic [15:0] UNITY = 16'd32768;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor divisors (2n+1)(2n+2) for n = 0..7
    localparam longint unsigned TAYLOR_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    // Control bits that travel with each queued item
    typedef struct packed {
        logic contrib;
        logic last;
        logic stereo;
    } t_item_ctl;

    // cos(k*pi/2 / 2^bits) in Q1.15, evaluated on constants only
    function automatic logic [15:0] quarter_cos(input int unsigned k, input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (longint'(k) * HALF_PI_Q30 + (64'd1 << (bits - 1))) >> bits;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int n = 0; n < 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                acc = acc + longint'(term);
            end else begin
                acc = acc - longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > 32768) begin
            acc = 32768;
        end
        return acc[15:0];
    endfunction

endpackage

@@ hdl/stereo_track_mixer_pan_top.sv @@
// Top level of the pan stereo mixer: front classifier, item queue and MAC back end.
// Depends on stmp_pkg, stmp_front, stmp_queue and stmp_back.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: left, right; tuser: track, present
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: mix_left, mix_right; tuser: clipped
//   cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Each item passes through the back end as table read, gain multiply, sample multiply and
// accumulate; an item with tlast adds master multiply and saturate into the output reg.
// A two-entry queue lets the input side take items while the back end works.
// Reset is synchronous; settings return to unity volume, center pan, stereo, sums zero.
// A stalled output holds the back end in its final stage; configuration is never stalled.
module stereo_track_mixer_pan_top #(
    parameter int TRACK_COUNT    = 4,
    parameter int SAMPLE_BITS    = 24,
    parameter int PAN_TABLE_BITS = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [2:0]                               i_cfg_index,
    input  logic [33:0]                              i_cfg_data,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // left_sample, right_sample (zero padded to bytes)
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // track_index [1:0], sample_present [2]
    input  logic [2:0]                               s_axis_tuser,
    input  logic                                     s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // mix_left, mix_right (zero padded to bytes)
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // clipped [0]
    output logic                                     m_axis_tuser
);

    localparam int DW   = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int IDXW = PAN_TABLE_BITS + 1;
    localparam int CW   = $bits(stmp_pkg::t_item_ctl);
    localparam int QW   = CW + 16 + IDXW + 2*SAMPLE_BITS;

    logic                        w_q_ready;
    logic                        w_push;
    stmp_pkg::t_item_ctl         w_f_ctl;
    logic [15:0]                 w_f_vol;
    logic [IDXW-1:0]             w_f_idx;
    logic [SAMPLE_BITS-1:0]      w_f_left;
    logic [SAMPLE_BITS-1:0]      w_f_right;
    logic [15:0]                 w_master;
    logic                        w_q_valid;
    logic                        w_pop;
    logic [QW-1:0]               w_q_data;
    stmp_pkg::t_item_ctl         w_b_ctl;
    logic [SAMPLE_BITS-1:0]      w_out_left;
    logic [SAMPLE_BITS-1:0]      w_out_right;

    assign o_cfg_ready = 1'b1;

    stmp_front #(
        .TRACK_COUNT    (TRACK_COUNT),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .PAN_TABLE_BITS (PAN_TABLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_track     (s_axis_tuser[1:0]),
        .i_present   (s_axis_tuser[2]),
        .i_last      (s_axis_tlast),
        .i_left      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_right     (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_q_ready   (w_q_ready),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_ctl       (w_f_ctl),
        .o_vol       (w_f_vol),
        .o_idx       (w_f_idx),
        .o_left      (w_f_left),
        .o_right     (w_f_right),
        .o_master    (w_master)
    );

    stmp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_ctl, w_f_vol, w_f_idx, w_f_left, w_f_right}),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_b_ctl = w_q_data[QW-1 -: CW];

    stmp_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .PAN_TABLE_BITS (PAN_TABLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_pop),
        .i_ctl     (w_b_ctl),
        .i_vol     (w_q_data[QW-CW-1 -: 16]),
        .i_idx     (w_q_data[2*SAMPLE_BITS +: IDXW]),
        .i_left    (w_q_data[SAMPLE_BITS +: SAMPLE_BITS]),
        .i_right   (w_q_data[SAMPLE_BITS-1:0]),
        .i_master  (w_master),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_left    (w_out_left),
        .o_right   (w_out_right),
        .o_clip    (m_axis_tuser)
    );

    assign m_axis_tdata = DW'({w_out_right, w_out_left});

endmodule

@@ hdl/stmp_front.sv @@
// Front end: configuration registers and per-item classification (skip, gain, pan index).
// Depends on stmp_pkg; feeds stmp_queue.
module stmp_front #(
    parameter int TRACK_COUNT    = 4,
    parameter int SAMPLE_BITS    = 24,
    parameter int PAN_TABLE_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write channel
    input  logic                        i_cfg_valid,
    input  logic [2:0]                  i_cfg_index,
    input  logic [33:0]                 i_cfg_data,
    // input item
    input  logic                        i_valid,
    input  logic [1:0]                  i_track,
    input  logic                        i_present,
    input  logic                        i_last,
    input  logic [SAMPLE_BITS-1:0]      i_left,
    input  logic [SAMPLE_BITS-1:0]      i_right,
    input  logic                        i_q_ready,
    output logic                        o_ready,
    // classified item toward the queue
    output logic                        o_push,
    output stmp_pkg::t_item_ctl         o_ctl,
    output logic [15:0]                 o_vol,
    output logic [PAN_TABLE_BITS:0]     o_idx,
    output logic [SAMPLE_BITS-1:0]      o_left,
    output logic [SAMPLE_BITS-1:0]      o_right,
    output logic [15:0]                 o_master
);

    localparam int IDXW  = PAN_TABLE_BITS + 1;
    localparam int STEPS = 1 << PAN_TABLE_BITS;
    localparam int SUMW  = 16 + PAN_TABLE_BITS + 1;

    logic [stmp_pkg::SETTING_BITS-1:0] r_setting [4];
    logic [15:0]                       r_master;
    logic                              r_mode;

    logic [stmp_pkg::SETTING_BITS-1:0] w_set;
    logic                              w_any_solo;
    logic                              w_track_ok;
    logic [15:0]                       w_pan_u;
    logic [SUMW-1:0]                   w_pan_scaled;
    logic [IDXW-1:0]                   w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_setting[k] <= stmp_pkg::SETTING_BITS'(stmp_pkg::UNITY);
            end
            r_master <= stmp_pkg::UNITY;
            r_mode   <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index < stmp_pkg::REG_MASTER) begin
                r_setting[i_cfg_index[1:0]] <= i_cfg_data;
            end else if (i_cfg_index == stmp_pkg::REG_MASTER) begin
                r_master <= i_cfg_data[15:0];
            end else if (i_cfg_index == stmp_pkg::REG_MODE) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    always_comb begin
        w_any_solo = 1'b0;
        for (int k = 0; k < TRACK_COUNT; k++) begin
            w_any_solo = w_any_solo | r_setting[k][stmp_pkg::BIT_SOLO];
        end
    end

    assign w_set      = r_setting[i_track];
    assign w_track_ok = ({1'b0, i_track} < 3'(TRACK_COUNT));

    // pan + 32768 as unsigned, then round to a table step
    assign w_pan_u      = {~w_set[31], w_set[30:16]};
    assign w_pan_scaled = {1'b0, w_pan_u, PAN_TABLE_BITS'(0)} + SUMW'(32768);
    assign w_idx        = (w_pan_scaled[SUMW-1:16] > IDXW'(STEPS)) ? IDXW'(STEPS)
                                                                   : w_pan_scaled[SUMW-1:16];

    assign o_ready = i_q_ready;
    assign o_push  = i_valid & i_q_ready;

    assign o_ctl.contrib = i_present & w_track_ok & ~w_set[stmp_pkg::BIT_MUTE]
                           & ~(w_any_solo & ~w_set[stmp_pkg::BIT_SOLO]);
    assign o_ctl.last    = i_last;
    assign o_ctl.stereo  = r_mode;
    assign o_vol    = (w_set[15:0] > stmp_pkg::UNITY) ? stmp_pkg::UNITY : w_set[15:0];
    assign o_idx    = w_idx;
    assign o_left   = i_left;
    assign o_right  = i_right;
    assign o_master = (r_master > stmp_pkg::UNITY) ? stmp_pkg::UNITY : r_master;

endmodule

@@ hdl/stmp_queue.sv @@
// Two-entry queue that decouples classification from the multiply-accumulate back end.
// No dependencies.
module stmp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_data;
                r_wptr        <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ hdl/stmp_back.sv @@
// Back end: pan table lookup, gain and sample multiplies, saturating sums, master scaling.
// Depends on stmp_pkg; pops stmp_queue and drives the output register.
module stmp_back #(
    parameter int SAMPLE_BITS    = 24,
    parameter int PAN_TABLE_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  stmp_pkg::t_item_ctl         i_ctl,
    input  logic [15:0]                 i_vol,
    input  logic [PAN_TABLE_BITS:0]     i_idx,
    input  logic [SAMPLE_BITS-1:0]      i_left,
    input  logic [SAMPLE_BITS-1:0]      i_right,
    input  logic [15:0]                 i_master,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [SAMPLE_BITS-1:0]      o_left,
    output logic [SAMPLE_BITS-1:0]      o_right,
    output logic                        o_clip
);

    localparam int IDXW  = PAN_TABLE_BITS + 1;
    localparam int STEPS = 1 << PAN_TABLE_BITS;
    localparam int PW    = SAMPLE_BITS + 18;
    localparam int TW    = PW - 15;
    localparam int AW    = ((TW > 32) ? TW : 32) + 1;
    localparam int MW    = 50;
    localparam int OW    = MW - 15;

    localparam logic signed [AW-1:0] S32_MAX = AW'(32'sh7fffffff);
    localparam logic signed [AW-1:0] S32_MIN = -S32_MAX - AW'(1);
    localparam logic signed [OW-1:0] OUT_MAX = (OW'(1) <<< (SAMPLE_BITS - 1)) - OW'(1);
    localparam logic signed [OW-1:0] OUT_MIN = -OUT_MAX - OW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GMUL,
        S_SMUL,
        S_ACC,
        S_MST,
        S_OUT
    } t_state;

    t_state                         r_state;
    stmp_pkg::t_item_ctl            r_ctl;
    logic [15:0]                    r_vol;
    logic [15:0]                    r_cos;
    logic [15:0]                    r_sin;
    logic [15:0]                    r_gl;
    logic [15:0]                    r_gr;
    logic signed [SAMPLE_BITS-1:0]  r_l;
    logic signed [SAMPLE_BITS-1:0]  r_r;
    logic signed [TW-1:0]           r_tl;
    logic signed [TW-1:0]           r_tr;
    logic signed [31:0]             r_left_sum;
    logic signed [31:0]             r_right_sum;
    logic signed [OW-1:0]           r_ml;
    logic signed [OW-1:0]           r_mr;
    logic                           r_out_valid;
    logic [SAMPLE_BITS-1:0]         r_out_left;
    logic [SAMPLE_BITS-1:0]         r_out_right;
    logic                           r_out_clip;

    logic [15:0]                    w_tab [STEPS+1];
    logic [IDXW-1:0]                w_sidx;
    logic [32:0]                    w_gl_p;
    logic [32:0]                    w_gr_p;
    logic signed [PW-1:0]           w_pl;
    logic signed [PW-1:0]           w_pr;
    logic signed [AW-1:0]           w_ls;
    logic signed [AW-1:0]           w_rs;
    logic signed [MW-1:0]           w_mlp;
    logic signed [MW-1:0]           w_mrp;
    logic                           w_clip_l;
    logic                           w_clip_r;
    logic signed [OW-1:0]           w_sat_l;
    logic signed [OW-1:0]           w_sat_r;
    logic                           w_out_free;

    for (genvar k = 0; k <= STEPS; k++) begin : g_tab
        assign w_tab[k] = stmp_pkg::quarter_cos(k, PAN_TABLE_BITS);
    end

    assign w_sidx = IDXW'(STEPS) - i_idx;

    // gain = rnd15(table * volume), never above unity
    assign w_gl_p = 33'(r_cos) * 33'(r_vol) + 33'd16384;
    assign w_gr_p = 33'(r_sin) * 33'(r_vol) + 33'd16384;

    assign w_pl = $signed(r_l) * $signed({1'b0, r_gl}) + PW'(16384);
    assign w_pr = $signed(r_r) * $signed({1'b0, r_gr}) + PW'(16384);

    assign w_ls = AW'(r_left_sum) + AW'(r_tl);
    assign w_rs = AW'(r_right_sum) + AW'(r_tr);

    assign w_mlp = $signed(r_left_sum) * $signed({1'b0, i_master}) + MW'(16384);
    assign w_mrp = $signed(r_right_sum) * $signed({1'b0, i_master}) + MW'(16384);

    assign w_clip_l = (r_ml > OUT_MAX) || (r_ml < OUT_MIN);
    assign w_clip_r = r_ctl.stereo && ((r_mr > OUT_MAX) || (r_mr < OUT_MIN));
    assign w_sat_l  = (r_ml > OUT_MAX) ? OUT_MAX : ((r_ml < OUT_MIN) ? OUT_MIN : r_ml);
    assign w_sat_r  = !r_ctl.stereo ? OW'(0)
                    : ((r_mr > OUT_MAX) ? OUT_MAX : ((r_mr < OUT_MIN) ? OUT_MIN : r_mr));

    assign w_out_free = !r_out_valid || i_ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left_sum  <= '0;
            r_right_sum <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ctl   <= i_ctl;
                        r_vol   <= i_vol;
                        r_cos   <= w_tab[i_idx];
                        r_sin   <= w_tab[w_sidx];
                        r_l     <= $signed(i_left);
                        r_r     <= $signed(i_right);
                        r_state <= S_GMUL;
                    end
                end
                S_GMUL: begin
                    if (r_ctl.stereo) begin
                        r_gl <= w_gl_p[30:15];
                        r_gr <= w_gr_p[30:15];
                    end else begin
                        r_gl <= r_vol;
                        r_gr <= '0;
                    end
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_tl    <= w_pl[PW-1:15];
                    r_tr    <= w_pr[PW-1:15];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_ctl.contrib) begin
                        r_left_sum  <= (w_ls > S32_MAX) ? 32'sh7fffffff
                                     : ((w_ls < S32_MIN) ? 32'sh80000000 : w_ls[31:0]);
                        r_right_sum <= (w_rs > S32_MAX) ? 32'sh7fffffff
                                     : ((w_rs < S32_MIN) ? 32'sh80000000 : w_rs[31:0]);
                    end
                    r_state <= r_ctl.last ? S_MST : S_IDLE;
                end
                S_MST: begin
                    r_ml    <= w_mlp[MW-1:15];
                    r_mr    <= w_mrp[MW-1:15];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the frame until the output register frees up
                    if (w_out_free) begin
                        r_out_left  <= w_sat_l[SAMPLE_BITS-1:0];
                        r_out_right <= w_sat_r[SAMPLE_BITS-1:0];
                        r_out_clip  <= w_clip_l || w_clip_r;
                        r_left_sum  <= '0;
                        r_right_sum <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_left  = r_out_left;
    assign o_right = r_out_right;
    assign o_clip  = r_out_clip;

    a_gain_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SMUL) |-> (r_gl <= stmp_pkg::UNITY) && (r_gr <= stmp_pkg::UNITY))
        else $error("pan gain above unity");

    a_out_after_master: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ($past(r_state) == S_MST) || ($past(r_state) == S_OUT))
        else $error("output stage entered without master scaling");

    a_clip_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |->
            ($signed(r_out_left) == OUT_MAX[SAMPLE_BITS-1:0]) ||
            ($signed(r_out_left) == OUT_MIN[SAMPLE_BITS-1:0]) ||
            ($signed(r_out_right) == OUT_MAX[SAMPLE_BITS-1:0]) ||
            ($signed(r_out_right) == OUT_MIN[SAMPLE_BITS-1:0]))
        else $error("clip flag without a saturated channel");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_left_sum == 0) && (r_right_sum == 0))
        else $error("sums not cleared after frame");

endmodule

@@ tb/tb_stereo_track_mixer_pan_top.sv @@
// Self-checking testbench for stereo_track_mixer_pan_top: directed and random track items,
// register writes between phases, random stalls on both stream sides.
// Depends on stmp_pkg and the mixer RTL; an in-bench mixer model predicts every frame.
module tb_stereo_track_mixer_pan_top;

    localparam int SAMPLE_BITS  = 24;
    localparam int PAN_BITS     = 8;
    localparam int PAN_STEPS    = 1 << PAN_BITS;
    localparam int DATA_BITS    = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int MAX_WAIT     = 13;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 3000;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [2:0] REG_TRACK0  = 3'd0;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam logic       MODE_MONO   = 1'b0;
    localparam logic       MODE_STEREO = 1'b1;

    localparam logic [SAMPLE_BITS-1:0] FULL_POS = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] FULL_NEG = 24'h800000;

    typedef struct {
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic                   clip;
    } t_mix_frame;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index   = '0;
    logic [33:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_BITS-1:0] s_axis_tdata  = '0;
    logic [2:0]           s_axis_tuser  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_BITS-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // mixer model state
    logic [15:0] cos_tab [0:PAN_STEPS];
    logic [33:0] pred_track [4];
    logic [15:0] pred_master;
    logic        pred_mode;
    longint      left_acc;
    longint      right_acc;
    t_mix_frame  mix_expected [$];

    // settings the next phase writes
    logic [33:0] want_track [4];
    logic [15:0] want_master;
    logic        want_mode;

    int send_gap_next = 0;
    int send_calm     = 0;
    int recv_calm     = 0;
    int items_sent    = 0;
    int frames_seen   = 0;
    int cfg_writes    = 0;
    int err_count     = 0;
    int idle_cycles   = 0;

    stereo_track_mixer_pan_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cos(k * pi/2 / 2^PAN_BITS) in Q1.15 by a Q30 Taylor series
    function automatic logic [15:0] cos_q15(input int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          series;
        int              n;
        ang    = (64'(k) * stmp_pkg::HALF_PI_Q30 + (64'd1 << (PAN_BITS - 1))) >> PAN_BITS;
        ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
        term   = 64'd1 << 30;
        series = longint'(term);
        for (n = 0; n < 8; n++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n + 1) * (2 * n + 2));
            if (n % 2 == 1) begin
                series = series + longint'(term);
            end else begin
                series = series - longint'(term);
            end
        end
        if (series < 0) begin
            series = 0;
        end
        series = (series + 16384) >>> 15;
        if (series > 32768) begin
            series = 32768;
        end
        return series[15:0];
    endfunction

    function automatic longint rnd_q15(input longint x);
        return (x + 16384) >>> 15;
    endfunction

    function automatic longint sat_to(input longint x, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (x > hi) begin
            return hi;
        end
        if (x < -hi - 1) begin
            return -hi - 1;
        end
        return x;
    endfunction

    function automatic longint clamp_gain(input logic [15:0] g);
        return (g > stmp_pkg::UNITY) ? longint'(stmp_pkg::UNITY) : longint'(g);
    endfunction

    task automatic reset_mixer_model();
        int k;
        for (k = 0; k < 4; k++) begin
            pred_track[k] = 34'(stmp_pkg::UNITY);
            want_track[k] = 34'(stmp_pkg::UNITY);
        end
        pred_master = stmp_pkg::UNITY;
        want_master = stmp_pkg::UNITY;
        pred_mode   = MODE_STEREO;
        want_mode   = MODE_STEREO;
        left_acc    = 0;
        right_acc   = 0;
    endtask

    task automatic note_register_write(input logic [2:0] idx, input logic [33:0] value);
        case (idx)
            stmp_pkg::REG_MASTER: pred_master = value[15:0];
            stmp_pkg::REG_MODE: pred_mode = value[0];
            REG_SPARE_A, REG_SPARE_B: ;
            default: pred_track[idx[1:0]] = value;
        endcase
    endtask

    // accumulate one track item; on the frame's last item push the expected mix
    task automatic mix_track_item(input logic [1:0] trk,
                                  input logic signed [SAMPLE_BITS-1:0] smp_l,
                                  input logic signed [SAMPLE_BITS-1:0] smp_r,
                                  input logic present, input logic last);
        logic [33:0] s;
        bit          any_solo;
        longint      vol;
        longint      pan;
        longint      gl;
        longint      gr;
        longint      mv;
        longint      raw_l;
        longint      raw_r;
        longint      out_l;
        longint      out_r;
        int          idx;
        int          k;
        t_mix_frame  frame;
        any_solo = 0;
        for (k = 0; k < 4; k++) begin
            if (pred_track[k][stmp_pkg::BIT_SOLO]) begin
                any_solo = 1;
            end
        end
        s = pred_track[trk];
        if (present && !s[stmp_pkg::BIT_MUTE] && !(any_solo && !s[stmp_pkg::BIT_SOLO])) begin
            vol = clamp_gain(s[15:0]);
            if (pred_mode == MODE_STEREO) begin
                pan = longint'($signed(s[31:16]));
                idx = int'((((pan + 32768) << PAN_BITS) + 32768) >> 16);
                if (idx > PAN_STEPS) begin
                    idx = PAN_STEPS;
                end
                gl = rnd_q15(longint'(cos_tab[idx]) * vol);
                gr = rnd_q15(longint'(cos_tab[PAN_STEPS - idx]) * vol);
                left_acc  = sat_to(left_acc + rnd_q15(longint'(smp_l) * gl), 32);
                right_acc = sat_to(right_acc + rnd_q15(longint'(smp_r) * gr), 32);
            end else begin
                left_acc = sat_to(left_acc + rnd_q15(longint'(smp_l) * vol), 32);
            end
        end
        if (last) begin
            mv    = clamp_gain(pred_master);
            raw_l = rnd_q15(left_acc * mv);
            out_l = sat_to(raw_l, SAMPLE_BITS);
            frame.clip = (raw_l != out_l);
            out_r = 0;
            if (pred_mode == MODE_STEREO) begin
                raw_r = rnd_q15(right_acc * mv);
                out_r = sat_to(raw_r, SAMPLE_BITS);
                frame.clip = frame.clip || (raw_r != out_r);
            end
            frame.left  = out_l[SAMPLE_BITS-1:0];
            frame.right = out_r[SAMPLE_BITS-1:0];
            mix_expected.push_back(frame);
            left_acc  = 0;
            right_acc = 0;
        end
    endtask

    // pick a wait; now and then a quiet stretch with no waits at all
    task automatic draw_wait(inout int calm, output int cycles);
        if (calm > 0) begin
            calm--;
            cycles = 0;
        end else if ($urandom_range(0, 9) == 0) begin
            calm   = $urandom_range(8, 40);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, MAX_WAIT);
        end
    endtask

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_LIMIT) begin
            $display("mismatch on frame %0d: %s", frames_seen, what);
        end
    endtask

    // one input transfer; valid stays high when the next item follows at once
    task automatic send_track_item(input logic [1:0] trk, input logic [SAMPLE_BITS-1:0] smp_l,
                                   input logic [SAMPLE_BITS-1:0] smp_r,
                                   input logic present, input logic last);
        repeat (send_gap_next) @(posedge i_clk);
        s_axis_tdata  <= DATA_BITS'({smp_r, smp_l});
        s_axis_tuser  <= {present, trk};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mix_track_item(trk, smp_l, smp_r, present, last);
        items_sent++;
        draw_wait(send_calm, send_gap_next);
        if (send_gap_next > 0) begin
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [33:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        note_register_write(idx, value);
        cfg_writes++;
    endtask

    // drop input valid, wait out every expected frame, then let the back end settle
    task automatic wait_idle();
        // valid is already low when a gap follows the last item
        if (send_gap_next == 0) begin
            s_axis_tvalid <= 1'b0;
        end
        while (mix_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings();
        int k;
        wait_idle();
        for (k = 0; k < 4; k++) begin
            cfg_write(REG_TRACK0 + 3'(k), want_track[k]);
        end
        // upper data bits are junk the block must drop
        cfg_write(stmp_pkg::REG_MASTER, {18'($urandom), want_master});
        cfg_write(stmp_pkg::REG_MODE, {1'($urandom), 32'($urandom), want_mode});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [33:0] track_word(input logic [15:0] vol, input logic [15:0] pan,
                                               input logic mute, input logic solo);
        return {solo, mute, pan, vol};
    endfunction

    function automatic logic [33:0] rand_track_setting();
        logic [15:0] vol;
        logic [15:0] pan;
        case ($urandom_range(0, 5))
            0: vol = 16'd0;
            1: vol = stmp_pkg::UNITY;
            2: vol = 16'hFFFF;
            default: vol = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: pan = 16'h8000;
            1: pan = 16'h7FFF;
            2: pan = 16'h0000;
            default: pan = 16'($urandom);
        endcase
        return track_word(vol, pan, $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0);
    endfunction

    function automatic logic [15:0] rand_master();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return stmp_pkg::UNITY;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return FULL_POS;
            1: return FULL_NEG;
            2: return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_track_item(2'd0, FULL_POS, FULL_NEG, 1'b1, 1'b0);
        send_track_item(2'd1, FULL_NEG, FULL_POS, 1'b1, 1'b0);
        send_track_item(2'd2, '0, '0, 1'b1, 1'b0);
        send_track_item(2'd3, rand_sample(), rand_sample(), 1'b1, 1'b1);
    endtask

    task automatic test_gain_and_pan_extremes();
        want_track[0] = track_word(16'hFFFF, 16'h8000, 1'b0, 1'b0);
        want_track[1] = track_word(16'd0, 16'h7FFF, 1'b0, 1'b0);
        want_track[2] = track_word(stmp_pkg::UNITY, 16'h7FFF, 1'b0, 1'b0);
        want_track[3] = track_word(16'd1, 16'h0000, 1'b0, 1'b0);
        want_master   = 16'hFFFF;
        want_mode     = MODE_STEREO;
        apply_settings();
        send_track_item(2'd0, 24'h400000, 24'h123456, 1'b1, 1'b0);
        send_track_item(2'd1, FULL_POS, FULL_POS, 1'b1, 1'b0);
        send_track_item(2'd2, 24'h0ABCDE, 24'hC00000, 1'b1, 1'b0);
        send_track_item(2'd3, FULL_NEG, FULL_POS, 1'b1, 1'b1);
    endtask

    task automatic test_output_clip();
        // hard left on tracks 0 and 1, hard right on tracks 2 and 3
        want_track[0] = track_word(stmp_pkg::UNITY, 16'h8000, 1'b0, 1'b0);
        want_track[1] = track_word(stmp_pkg::UNITY, 16'h8000, 1'b0, 1'b0);
        want_track[2] = track_word(stmp_pkg::UNITY, 16'h7FFF, 1'b0, 1'b0);
        want_track[3] = track_word(stmp_pkg::UNITY, 16'h7FFF, 1'b0, 1'b0);
        want_master   = stmp_pkg::UNITY;
        apply_settings();
        send_track_item(2'd0, FULL_POS, '0, 1'b1, 1'b0);
        send_track_item(2'd1, FULL_POS, '0, 1'b1, 1'b0);
        send_track_item(2'd2, '0, FULL_NEG, 1'b1, 1'b0);
        send_track_item(2'd3, '0, FULL_NEG, 1'b1, 1'b1);
    endtask

    task automatic test_mute_and_solo();
        want_track[0] = track_word(stmp_pkg::UNITY, 16'h0000, 1'b1, 1'b0);
        want_track[1] = track_word(stmp_pkg::UNITY, 16'h0000, 1'b0, 1'b0);
        want_track[2] = track_word(stmp_pkg::UNITY, 16'h1000, 1'b0, 1'b1);
        want_track[3] = track_word(stmp_pkg::UNITY, 16'hF000, 1'b1, 1'b1);
        apply_settings();
        send_track_item(2'd0, FULL_POS, FULL_POS, 1'b1, 1'b0);
        send_track_item(2'd1, FULL_POS, FULL_POS, 1'b1, 1'b0);
        send_track_item(2'd2, 24'h345678, 24'hE00000, 1'b1, 1'b0);
        send_track_item(2'd3, FULL_NEG, FULL_NEG, 1'b1, 1'b1);
    endtask

    task automatic test_empty_frame();
        reset_mixer_model_wants();
        apply_settings();
        send_track_item(2'd0, FULL_POS, FULL_POS, 1'b0, 1'b0);
        send_track_item(2'd3, FULL_NEG, FULL_NEG, 1'b0, 1'b1);
        // a frame made of a single absent item
        send_track_item(2'd1, rand_sample(), rand_sample(), 1'b0, 1'b1);
    endtask

    task automatic reset_mixer_model_wants();
        int k;
        for (k = 0; k < 4; k++) begin
            want_track[k] = 34'(stmp_pkg::UNITY);
        end
        want_master = stmp_pkg::UNITY;
        want_mode   = MODE_STEREO;
    endtask

    task automatic test_mode_change_mid_frame();
        want_track[1] = track_word(16'h6000, 16'hC000, 1'b0, 1'b0);
        apply_settings();
        send_track_item(2'd0, 24'h200000, 24'h300000, 1'b1, 1'b0);
        send_track_item(2'd1, 24'hF00000, 24'h100000, 1'b1, 1'b0);
        want_mode = MODE_MONO;
        apply_settings();
        send_track_item(2'd2, 24'h111111, 24'h222222, 1'b1, 1'b0);
        send_track_item(2'd3, 24'hE00000, FULL_POS, 1'b1, 1'b1);
        send_track_item(2'd0, 24'h050505, FULL_NEG, 1'b1, 1'b0);
        want_mode = MODE_STEREO;
        apply_settings();
        send_track_item(2'd1, 24'h300000, 24'h2AAAAA, 1'b1, 1'b1);
    endtask

    task automatic test_unknown_register();
        wait_idle();
        cfg_write(REG_SPARE_A, 34'(~64'd0));
        cfg_write(REG_SPARE_B, {2'($urandom), 32'($urandom)});
        i_cfg_valid <= 1'b0;
        send_track_item(2'd2, 24'h765432, 24'h0F0F0F, 1'b1, 1'b1);
    endtask

    task automatic test_sum_saturation();
        int n;
        reset_mixer_model_wants();
        want_mode   = MODE_MONO;
        want_master = 16'd64;
        apply_settings();
        // enough near-full-scale items to push the left running sum past 32 bits, both ways
        for (n = 0; n < 280; n++) begin
            send_track_item(2'd0, SAMPLE_BITS'($urandom_range(8000000, 8388607)), rand_sample(),
                            1'b1, n == 279);
        end
        for (n = 0; n < 280; n++) begin
            send_track_item(2'd0, SAMPLE_BITS'(-$signed($urandom_range(8000000, 8388608))),
                            rand_sample(), 1'b1, n == 279);
        end
    endtask

    task automatic test_random_frames();
        int phase;
        int sent;
        int n;
        int j;
        int k;
        for (phase = 0; phase < 10; phase++) begin
            for (k = 0; k < 4; k++) begin
                want_track[k] = rand_track_setting();
            end
            want_master = rand_master();
            want_mode   = 1'($urandom);
            if (phase == 0) begin
                for (k = 0; k < 4; k++) begin
                    want_track[k] = track_word(16'hFFFF, (k % 2 == 0) ? 16'h8000 : 16'h7FFF,
                                               1'b0, 1'b0);
                end
                want_master = 16'hFFFF;
                want_mode   = MODE_STEREO;
            end else if (phase == 1) begin
                for (k = 0; k < 4; k++) begin
                    want_track[k] = track_word(16'd0, 16'($urandom), 1'b0, 1'b0);
                end
                want_master = 16'd0;
                want_mode   = MODE_MONO;
            end
            apply_settings();
            sent = 0;
            while (sent < 130) begin
                if ($urandom_range(0, 4) != 0) begin
                    // well-formed frame: tracks in order, last on the final one
                    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 4;
                    for (j = 0; j < n; j++) begin
                        send_track_item(2'(j), rand_sample(), rand_sample(),
                                        $urandom_range(0, 7) != 0, j == n - 1);
                    end
                end else begin
                    n = $urandom_range(1, 3);
                    for (j = 0; j < n; j++) begin
                        send_track_item(2'($urandom), rand_sample(), rand_sample(),
                                        1'($urandom), $urandom_range(0, 2) == 0);
                    end
                end
                sent += n;
            end
        end
    endtask

    // output side: random stalls, one draw per transfer
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            draw_wait(recv_calm, stall);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_mix_frame want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mix_expected.size() == 0) begin
                report_mismatch($sformatf("frame %h/%b with nothing expected",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = mix_expected.pop_front();
                if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.left) begin
                    report_mismatch($sformatf("mix_left %h, expected %h",
                                              m_axis_tdata[SAMPLE_BITS-1:0], want.left));
                end
                if (m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.right) begin
                    report_mismatch($sformatf("mix_right %h, expected %h",
                                              m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
                                              want.right));
                end
                if (m_axis_tuser !== want.clip) begin
                    report_mismatch($sformatf("clipped %b, expected %b",
                                              m_axis_tuser, want.clip));
                end
            end
            frames_seen++;
        end
    end

    // end the run when no channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d frames still expected",
                     STALL_LIMIT, mix_expected.size());
            $display("tb_stereo_track_mixer_pan_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run
        int k;
        for (k = 0; k <= PAN_STEPS; k++) begin
            cos_tab[k] = cos_q15(k);
        end
        reset_mixer_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_gain_and_pan_extremes();
        test_output_clip();
        test_mute_and_solo();
        test_empty_frame();
        test_mode_change_mid_frame();
        test_unknown_register();
        test_sum_saturation();
        test_random_frames();
        wait_idle();
        $display("covered %0d track items and %0d mixed frames over %0d register writes,",
                 items_sent, frames_seen, cfg_writes);
        $display("mono and stereo, gain and pan extremes, mute/solo, clipping, sum overflow");
        if (err_count == 0 && mix_expected.size() == 0) begin
            $display("tb_stereo_track_mixer_pan_top: done, clean");
        end else begin
            $display("tb_stereo_track_mixer_pan_top: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/stmp_pkg.sv
hdl/stmp_front.sv
hdl/stmp_queue.sv
hdl/stmp_back.sv
hdl/stereo_track_mixer_pan_top.sv
tb/tb_stereo_track_mixer_pan_top.sv
